// File: rtl/n3u_pkg.sv
// Package: shared types, constants and the code-to-ASCII translation for the 3-bit unpacker.
package n3u_pkg;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [7:0] CHAR_A    = 8'h41;
    localparam logic [7:0] CHAR_C    = 8'h43;
    localparam logic [7:0] CHAR_G    = 8'h47;
    localparam logic [7:0] CHAR_T    = 8'h54;
    localparam logic [7:0] CHAR_U    = 8'h55;
    localparam logic [7:0] CHAR_GAP  = 8'h2D;
    localparam logic [7:0] CHAR_NONE = 8'h00;

    localparam logic [2:0] CODE_NONE = 3'd0;
    localparam logic [2:0] CODE_A    = 3'd1;
    localparam logic [2:0] CODE_C    = 3'd2;
    localparam logic [2:0] CODE_G    = 3'd3;
    localparam logic [2:0] CODE_T    = 3'd4;
    localparam logic [2:0] CODE_U    = 3'd5;
    localparam logic [2:0] CODE_GAP  = 3'd6;

    localparam logic [7:0] MASK_P0_TAIL = 8'd56;
    localparam logic [7:0] MASK_P1_BOTH = 8'd126;
    localparam logic [7:0] MASK_P1_TAIL = 8'd112;
    localparam logic [7:0] MASK_P2_BOTH = 8'd252;
    localparam logic [7:0] MASK_P2_TAIL = 8'd224;

    typedef struct packed {
        logic [2:0][2:0] codes;
        logic [1:0]      count;
        logic            fin;
    } n3u_job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } n3u_qstat_t;

    function automatic logic [7:0] n3u_translate(input logic [2:0] code,
                                                 input logic [7:0] na_symbol);
        logic [7:0] ch;
        case (code)
            CODE_NONE: ch = CHAR_NONE;
            CODE_A:    ch = CHAR_A;
            CODE_C:    ch = CHAR_C;
            CODE_G:    ch = CHAR_G;
            CODE_T:    ch = CHAR_T;
            CODE_U:    ch = CHAR_U;
            CODE_GAP:  ch = CHAR_GAP;
            default:   ch = na_symbol;
        endcase
        return ch;
    endfunction

endpackage

// File: rtl/n3u_ifs.sv
// Interfaces: packed byte input, symbol output and configuration write channels.
interface n3u_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] packed_byte;
    logic       is_final;

    modport source (output valid, output packed_byte, output is_final, input ready);
    modport sink   (input valid, input packed_byte, input is_final, output ready);
endinterface

interface n3u_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] symbol_char;
    logic       end_of_run;
    logic       end_of_sequence;

    modport source (output valid, output symbol_char, output end_of_run,
                    output end_of_sequence, input ready);
    modport sink   (input valid, input symbol_char, input end_of_run,
                    input end_of_sequence, output ready);
endinterface

interface n3u_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] na_symbol;

    modport source (output valid, output na_symbol, input ready);
    modport sink   (input valid, input na_symbol, output ready);
endinterface

// File: rtl/nucleotide_3bit_unpacker.sv
// Top level: 3-bit packed nucleotide unpacker with front end, job queue and symbol emitter.
// Each accepted byte yields one to three symbols on symbol_stream, one symbol per cycle
// while symbol_stream is ready: two or three in steady state (three bytes give eight
// symbols), one to three on the final byte of a sequence. The front end splits a byte
// in the cycle it is accepted and parks it in a QUEUE_DEPTH-entry queue, so a new byte
// is taken while earlier symbols still drain. Each symbol is translated from the queue
// head job into a registered output. na_symbol is written through cfg, which is always ready.
module nucleotide_3bit_unpacker #(
    parameter int QUEUE_DEPTH = n3u_pkg::QUEUE_DEPTH
) (
    input  logic      clk,
    input  logic      rst_n,
    n3u_in_if.sink    packed_stream,
    n3u_out_if.source symbol_stream,
    n3u_cfg_if.sink   cfg
);

    logic [7:0]          na_symbol_reg;
    logic                push;
    logic                pop;
    n3u_pkg::n3u_job_t   push_job;
    n3u_pkg::n3u_job_t   head_job;
    n3u_pkg::n3u_qstat_t qstat;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            na_symbol_reg <= 8'd0;
        else if (cfg.valid)
            na_symbol_reg <= cfg.na_symbol;
    end

    n3u_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .packed_stream (packed_stream),
        .qstat         (qstat),
        .push          (push),
        .job           (push_job)
    );

    n3u_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .qstat    (qstat)
    );

    n3u_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_job      (head_job),
        .qstat         (qstat),
        .na_symbol     (na_symbol_reg),
        .pop           (pop),
        .symbol_stream (symbol_stream)
    );

    a_eos_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        symbol_stream.valid && symbol_stream.end_of_sequence |-> symbol_stream.end_of_run)
        else $error("end_of_sequence without end_of_run");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !qstat.empty)
        else $error("queue popped while empty");

    a_full_stalls_input: assert property (@(posedge clk) disable iff (!rst_n)
        qstat.full |-> !packed_stream.ready)
        else $error("input ready while queue full");

    a_job_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        !qstat.empty |-> head_job.count != 2'd0)
        else $error("queued job with no symbols");

endmodule

// File: rtl/n3u_front.sv
// Front end: accepts packed bytes, splits them into 3-bit codes and trims the final byte.
module n3u_front (
    input  logic                clk,
    input  logic                rst_n,
    n3u_in_if.sink              packed_stream,
    input  n3u_pkg::n3u_qstat_t qstat,
    output logic                push,
    output n3u_pkg::n3u_job_t   job
);

    localparam logic [1:0] PHASE0 = 2'd0;
    localparam logic [1:0] PHASE1 = 2'd1;
    localparam logic [1:0] PHASE2 = 2'd2;

    logic [1:0] phase_reg, phase_next;
    logic [1:0] carry_reg, carry_next;
    logic [7:0] b;
    logic       fin;
    logic [1:0] drop;
    logic [1:0] full_count;

    assign b   = packed_stream.packed_byte;
    assign fin = packed_stream.is_final;

    assign packed_stream.ready = !qstat.full;
    assign push = packed_stream.valid && !qstat.full;

    always_comb
    begin
        drop = 2'd0;
        case (phase_reg)
            PHASE1:
            begin
                job.codes[0] = {b[0], carry_reg};
                job.codes[1] = b[3:1];
                job.codes[2] = b[6:4];
                full_count   = 2'd3;
                carry_next   = {1'b0, b[7]};
                phase_next   = PHASE2;
                if ((b & n3u_pkg::MASK_P1_BOTH) == 8'd0)
                    drop = 2'd2;
                else if ((b & n3u_pkg::MASK_P1_TAIL) == 8'd0)
                    drop = 2'd1;
            end
            PHASE2:
            begin
                job.codes[0] = {b[1:0], carry_reg[0]};
                job.codes[1] = b[4:2];
                job.codes[2] = b[7:5];
                full_count   = 2'd3;
                carry_next   = 2'd0;
                phase_next   = PHASE0;
                if ((b & n3u_pkg::MASK_P2_BOTH) == 8'd0)
                    drop = 2'd2;
                else if ((b & n3u_pkg::MASK_P2_TAIL) == 8'd0)
                    drop = 2'd1;
            end
            default:
            begin
                job.codes[0] = b[2:0];
                job.codes[1] = b[5:3];
                job.codes[2] = n3u_pkg::CODE_NONE;
                full_count   = 2'd2;
                carry_next   = b[7:6];
                phase_next   = PHASE1;
                if ((b & n3u_pkg::MASK_P0_TAIL) == 8'd0)
                    drop = 2'd1;
            end
        endcase
        if (!fin)
            drop = 2'd0;
        else
        begin
            carry_next = 2'd0;
            phase_next = PHASE0;
        end
        job.count = full_count - drop;
        job.fin   = fin;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PHASE0;
            carry_reg <= 2'd0;
        end
        else if (push)
        begin
            phase_reg <= phase_next;
            carry_reg <= carry_next;
        end
    end

endmodule

// File: rtl/n3u_queue.sv
// Queue: short job FIFO between the front end and the symbol emitter.
module n3u_queue #(
    parameter int DEPTH = n3u_pkg::QUEUE_DEPTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  n3u_pkg::n3u_job_t   push_job,
    input  logic                pop,
    output n3u_pkg::n3u_job_t   head_job,
    output n3u_pkg::n3u_qstat_t qstat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    n3u_pkg::n3u_job_t entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign qstat.full  = (count_reg == CNT_W'(DEPTH));
    assign qstat.empty = (count_reg == '0);
    assign head_job    = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_job;
    end

endmodule

// File: rtl/n3u_back.sv
// Back end: walks each queued job one symbol per cycle, while the output is ready, into a registered output.
module n3u_back (
    input  logic                clk,
    input  logic                rst_n,
    input  n3u_pkg::n3u_job_t   head_job,
    input  n3u_pkg::n3u_qstat_t qstat,
    input  logic [7:0]          na_symbol,
    output logic                pop,
    n3u_out_if.source           symbol_stream
);

    logic [1:0] idx_reg, idx_next;
    logic       valid_reg, valid_next;
    logic [7:0] char_reg;
    logic       eor_reg;
    logic       eos_reg;
    logic       load;
    logic       last;

    assign load = !qstat.empty && (!valid_reg || symbol_stream.ready);
    assign last = (idx_reg == head_job.count - 2'd1);
    assign pop  = load && last;

    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (load)
        begin
            idx_next   = last ? 2'd0 : idx_reg + 2'd1;
            valid_next = 1'b1;
        end
        else if (symbol_stream.ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= 2'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            char_reg <= n3u_pkg::n3u_translate(head_job.codes[idx_reg], na_symbol);
            eor_reg  <= last;
            eos_reg  <= last && head_job.fin;
        end
    end

    assign symbol_stream.valid           = valid_reg;
    assign symbol_stream.symbol_char     = char_reg;
    assign symbol_stream.end_of_run      = eor_reg;
    assign symbol_stream.end_of_sequence = eos_reg;

endmodule
